// File: rtl/telepen_symbol_encoder_defines.svh
// Assertion macros for the Telepen symbol encoder
`ifndef TELEPEN_SYMBOL_ENCODER_DEFINES_SVH
`define TELEPEN_SYMBOL_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define TSE_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: check failed");
`define TSE_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: check failed");
`else
`define TSE_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TSE_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/tse_pkg.sv
`timescale 1ns / 1ps
package tse_pkg;

  localparam logic [6:0] GLYPH_START = 7'd95;
  localparam logic [6:0] GLYPH_STOP  = 7'd122;
  localparam logic [6:0] SUM_MOD     = 7'd127;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_CHECK = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_LONG = 2'd1,
    ERR_INVALID  = 2'd2
  } err_t;

  // One classified item: which results it causes
  typedef struct packed {
    logic       has_err;
    err_t       err;
    logic       has_start;
    logic       has_data;
    logic [6:0] data;
    logic       has_end;
    logic [6:0] chk;
  } job_t;

  typedef struct packed {
    logic [15:0] widths;
    logic [4:0]  element_count;
    logic [6:0]  glyph;
    kind_t       kind;
    err_t        error_code;
    logic        end_of_run;
  } result_t;

  localparam int NUM_GLYPHS = 127;
  localparam logic [15:0] PAT_W [NUM_GLYPHS] = '{
    16'h0000,16'h0054,16'h0017,16'h0150,16'h0051,16'h005C,16'h005A,16'h0140,
    16'h001D,16'h0144,16'h0053,16'h0070,16'h0141,16'h0068,16'h0062,16'h0500,
    16'h0045,16'h0074,16'h001F,16'h0110,16'h0071,16'h004C,16'h004A,16'h01C0,
    16'h0069,16'h0104,16'h0043,16'h01A0,16'h0101,16'h0188,16'h0182,16'h0400,
    16'h0035,16'h0114,16'h0047,16'h00D0,16'h0111,16'h003C,16'h003A,16'h0440,
    16'h004D,16'h00C4,16'h0033,16'h0130,16'h00C1,16'h0128,16'h0122,16'h0300,
    16'h0105,16'h00A4,16'h002B,16'h0410,16'h00A1,16'h010C,16'h010A,16'h0280,
    16'h0089,16'h0404,16'h0103,16'h0220,16'h0401,16'h0208,16'h0202,16'h1000,
    16'h0015,16'h00D4,16'h0037,16'h0050,16'h00D1,16'h001C,16'h001A,16'h0340,
    16'h003D,16'h0044,16'h0013,16'h00F0,16'h0041,16'h00E8,16'h00E2,16'h0100,
    16'h00C5,16'h0034,16'h000F,16'h0310,16'h0031,16'h00CC,16'h00CA,16'h00C0,
    16'h0029,16'h0304,16'h00C3,16'h00A0,16'h0301,16'h0088,16'h0082,16'h0C00,
    16'h00A5,16'h0014,16'h0007,16'h0290,16'h0011,16'h00AC,16'h00AA,16'h0040,
    16'h000D,16'h0284,16'h00A3,16'h0030,16'h0281,16'h0028,16'h0022,16'h0A00,
    16'h0005,16'h0224,16'h008B,16'h0010,16'h0221,16'h000C,16'h000A,16'h0880,
    16'h0209,16'h0004,16'h0003,16'h0820,16'h0001,16'h0808,16'h0802
  };
  localparam logic [4:0] PAT_N [NUM_GLYPHS] = '{
    16,10,8,10,10,8,8,12, 8,10,8,10,10,10,10,12,
    10,8,6,12,8,10,10,10, 8,12,10,10,12,10,10,14,
    8,10,8,10,10,8,8,12, 8,10,8,10,10,10,10,12,
    10,10,8,12,10,10,10,12, 10,12,10,12,12,12,12,14,
    10,8,6,12,8,10,10,10, 6,12,10,8,12,8,8,14,
    8,10,8,10,10,8,8,12, 10,10,8,12,10,12,12,12,
    8,12,10,10,12,8,8,14, 10,10,8,12,10,12,12,12,
    12,10,8,14,10,12,12,12, 10,14,12,12,14,12,12
  };

  function automatic logic [15:0] pat_bits(input logic [6:0] g);
    logic [15:0] w;
    w = '0;
    if (g != SUM_MOD) w = PAT_W[g];
    return w;
  endfunction

endpackage

// File: rtl/tse_front.sv
`timescale 1ns / 1ps
module tse_front #(
  parameter int MAX_ASCII_CHARS = 30,
  parameter int MAX_DIGITS      = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          numeric_mode,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    ch,
  input  logic          first,
  input  logic          last,
  input  logic          odd_length,
  output logic          job_valid,
  output tse_pkg::job_t job,
  input  logic          job_ready
);
  import tse_pkg::*;

  logic [6:0] check_sum_r, check_sum_nxt;
  logic [6:0] char_count_r, char_count_nxt;
  logic [3:0] held_digit_r, held_digit_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       faulted_r, faulted_nxt;
  logic       go;

  assign in_tready = job_ready;
  assign go = in_tvalid && in_tready;

  always_comb begin
    logic [6:0] cs, cc, dat, s, c7;
    logic [3:0] hd;
    logic       hv, fl, err_on, hd_on, ix;
    logic [7:0] c;
    logic [7:0] sum8;
    err_t       e;
    cs = check_sum_r; cc = char_count_r; hd = held_digit_r;
    hv = held_valid_r; fl = faulted_r;
    dat = '0; hd_on = 1'b0; e = ERR_NONE; err_on = 1'b0;
    c = ch; ix = 1'b0; s = '0; c7 = '0; sum8 = '0;
    if (first) begin
      cs = '0; cc = '0; hd = '0; fl = 1'b0;
      hv = numeric_mode && odd_length;
    end
    job = '0;
    job_valid = 1'b0;
    if (!fl) begin
      job_valid = 1'b1;
      if (!numeric_mode) begin
        if (cc >= 7'(MAX_ASCII_CHARS)) e = ERR_TOO_LONG;
        else if (ch > 8'd126) e = ERR_INVALID;
        else begin cc = cc + 7'd1; dat = ch[6:0]; hd_on = 1'b1; end
      end else begin
        if (cc >= 7'(MAX_DIGITS)) e = ERR_TOO_LONG;
        else begin
          if (c >= "a" && c <= "z") c = c - 8'd32;
          ix = (c == "X");
          if (!ix && (c < "0" || c > "9")) e = ERR_INVALID;
          else begin
            cc = cc + 7'd1;
            if (!hv) begin
              if (ix) e = ERR_INVALID;
              else begin hd = c[3:0]; hv = 1'b1; end
            end else begin
              if (ix) dat = {3'd0, hd} + 7'd17;
              else dat = 7'({3'd0, hd} * 7'd10) + {3'd0, c[3:0]} + 7'd27;
              hv = 1'b0; hd_on = 1'b1;
            end
          end
        end
        if (e == ERR_NONE && last && hv) e = ERR_INVALID;
      end
      err_on = (e != ERR_NONE);
      if (err_on) fl = 1'b1;
      else if (hd_on) begin
        sum8 = {1'b0, cs} + {1'b0, dat};
        cs = (sum8 >= 8'd127) ? 7'(sum8 - 8'd127) : sum8[6:0];
      end
      s = cs;
      c7 = (s == 7'd0) ? 7'd0 : 7'(SUM_MOD - s);
      job.has_err = err_on;
      job.err = e;
      job.has_start = !err_on && first;
      job.has_data = !err_on && hd_on;
      job.data = dat;
      job.has_end = !err_on && last;
      job.chk = c7;
    end
    if (last) begin
      cs = '0; cc = '0; hd = '0; hv = 1'b0; fl = 1'b0;
    end
    check_sum_nxt = cs; char_count_nxt = cc; held_digit_nxt = hd;
    held_valid_nxt = hv; faulted_nxt = fl;
    if (!in_tvalid) job_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_sum_r <= '0; char_count_r <= '0; held_digit_r <= '0;
      held_valid_r <= 1'b0; faulted_r <= 1'b0;
    end else if (go) begin
      check_sum_r <= check_sum_nxt; char_count_r <= char_count_nxt;
      held_digit_r <= held_digit_nxt; held_valid_r <= held_valid_nxt;
      faulted_r <= faulted_nxt;
    end
  end
endmodule

// File: rtl/tse_queue.sv
`timescale 1ns / 1ps
module tse_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tse_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tse_pkg::job_t rd_job
);
  import tse_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: rtl/tse_back.sv
`timescale 1ns / 1ps
module tse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  tse_pkg::job_t    job,
  output logic             out_tvalid,
  input  logic             out_tready,
  output tse_pkg::result_t res
);
  import tse_pkg::*;

  // step 0 start, 1 data, 2 check, 3 stop
  logic [3:0] done_r, done_nxt;
  logic [3:0] need;
  logic [1:0] sel;
  logic [3:0] left;
  logic       fire;
  logic [6:0] g;
  kind_t      k;

  always_comb begin
    need = job.has_err ? 4'b0001 : {job.has_end, job.has_end, job.has_data, job.has_start};
    left = need & ~done_r;
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) if (left[i]) sel = 2'(i);
    g = '0; k = KIND_ERROR;
    res = '0;
    if (job.has_err) begin
      res.kind = KIND_ERROR; res.error_code = job.err;
    end else begin
      case (sel)
        2'd0: begin g = GLYPH_START; k = KIND_START; end
        2'd1: begin g = job.data; k = KIND_DATA; end
        2'd2: begin g = job.chk; k = KIND_CHECK; end
        2'd3: begin g = GLYPH_STOP; k = KIND_STOP; end
        default: begin g = '0; k = KIND_ERROR; end
      endcase
      res.glyph = g; res.kind = k; res.error_code = ERR_NONE;
      res.widths = pat_bits(g);
      res.element_count = (g == SUM_MOD) ? 5'd0 : PAT_N[g];
    end
    res.end_of_run = ((left & ~(4'b0001 << sel)) == 4'd0);
    out_tvalid = job_valid && (left != 4'd0);
    fire = out_tvalid && out_tready;
    job_ready = job_valid && ((left == 4'd0) || (fire && res.end_of_run));
    done_nxt = done_r;
    if (job_ready) done_nxt = '0;
    else if (fire) done_nxt = done_r | (4'b0001 << sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= '0;
    else done_r <= done_nxt;
  end
endmodule

// File: rtl/telepen_symbol_encoder.sv
// Telepen symbol encoder: one message character per in_ transfer, up to four glyph
// results (start, data, check, stop, or one error) per character, one result per
// cycle while out_tready is high. The front classifier classifies each item, the
// output sequencer sends its results; a two-entry job queue between them lets a new
// character be taken while results of the previous one drain. A character that causes
// no result (a held digit) still passes through the queue and the sequencer;
// characters of a dropped message are taken when the queue has room and leave no job.
`timescale 1ns / 1ps
`include "telepen_symbol_encoder_defines.svh"
module telepen_symbol_encoder #(
  parameter int MAX_ASCII_CHARS = 30,
  parameter int MAX_DIGITS      = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic [1:0]  in_tuser,   // first, odd_length
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // widths, element_count, glyph, error_code, zero pad
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast,  // end_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tse_pkg::*;

  logic    numeric_mode_r;
  logic    fv, fr, bv, br;
  job_t    fj, bj;
  result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, numeric_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) numeric_mode_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      numeric_mode_r <= cfg_pwdata[0];
  end

  tse_front #(.MAX_ASCII_CHARS(MAX_ASCII_CHARS), .MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk, .rst_n, .numeric_mode(numeric_mode_r), .in_tvalid, .in_tready,
    .ch(in_tdata), .first(in_tuser[0]), .last(in_tlast), .odd_length(in_tuser[1]),
    .job_valid(fv), .job(fj), .job_ready(fr)
  );

  tse_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(bv), .rd_ready(br), .rd_job(bj)
  );

  tse_back u_back (
    .clk, .rst_n, .job_valid(bv), .job_ready(br), .job(bj),
    .out_tvalid, .out_tready, .res
  );

  assign out_tdata = {2'b00, res.error_code, res.glyph, res.element_count, res.widths};
  assign out_tuser = res.kind;
  assign out_tlast = res.end_of_run;

  `TSE_ASSERT_IMPL(a_err_single, clk, rst_n,
    out_tvalid && out_tuser == KIND_ERROR, out_tlast)
  `TSE_ASSERT_IMPL(a_stop_last, clk, rst_n,
    out_tvalid && out_tuser == KIND_STOP, out_tlast && out_tdata[27:21] == GLYPH_STOP)
  `TSE_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))
endmodule
